FILE: design/bsp_pkg.sv
`default_nettype none
package bsp_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int MAX_DEGREE_DEF = 3;
    localparam int MAX_KNOTS_DEF  = 20;

    typedef enum logic [1:0] {
        FUNC_POINT = 2'd0,
        FUNC_KNOT  = 2'd1,
        FUNC_EVAL  = 2'd2
    } func_t;

    localparam logic REG_DEGREE     = 1'b0;
    localparam logic REG_NUM_POINTS = 1'b1;

    typedef logic signed [17:0] basis_t;

    localparam basis_t ONE_Q15 = 18'sd32768;
    localparam basis_t B_MAX   = 18'sd131071;
    localparam basis_t B_MIN   = -18'sd131072;

endpackage
`default_nettype wire

FILE: design/bsp_ram.sv
`default_nettype none
module bsp_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: design/bsp_div.sv
`default_nettype none
module bsp_div (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [16:0]   num,
    input  wire logic signed [16:0]   span,
    output logic                      done,
    output bsp_pkg::basis_t           quo
);
    import bsp_pkg::*;

    logic [15:0] rem_reg, rem_next;
    logic [15:0] den_reg;
    logic [31:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg, neg_reg;
    logic [16:0] num_abs, span_abs, trial;
    logic        ge;

    assign num_abs  = num[16] ? 17'(-num) : num;
    assign span_abs = span[16] ? 17'(-span) : span;
    assign trial    = {rem_reg, quo_reg[31]};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_next = ge ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
    assign quo_next = {quo_reg[30:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= {1'b0, num_abs[15:0], 15'd0};
            den_reg <= (span == 17'sd0) ? 16'd32768 : span_abs[15:0];
            neg_reg <= num[16] ^ ((span != 17'sd0) && span[16]);
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_comb begin
        if (neg_reg) begin
            quo = (quo_reg > 32'd131072) ? B_MIN : 18'(-$signed({1'b0, quo_reg[17:0]}));
        end else begin
            quo = (quo_reg > 32'd131071) ? B_MAX : $signed({1'b0, quo_reg[16:0]});
        end
    end

    assign done = done_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(busy_reg)) else $error("divider done without work");

endmodule
`default_nettype wire

FILE: design/bspline_curve_point_eval_unit.sv
`default_nettype none
// evaluate: count = np + degree,
// steps = sum over levels 1..degree of (count - level); each step runs the
// shared serial divider twice, which sets the rate
// point and knot writes are taken only while idle; one item at a time
// reset (synchronous, aresetn low): degree 3, num_points 4, no result pending;
// point and knot tables are not cleared
module bspline_curve_point_eval_unit #(
    parameter int MAX_POINTS = bsp_pkg::MAX_POINTS_DEF,
    parameter int MAX_DEGREE = bsp_pkg::MAX_DEGREE_DEF,
    parameter int MAX_KNOTS  = bsp_pkg::MAX_KNOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // index, point_x, point_y, value, zero pad
    input  wire logic [1:0]  s_tuser,  // func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // curve_x, curve_y
    output logic [0:0]       m_tuser,  // saturated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_addr,
    input  wire logic [4:0]  cfg_data
);
    import bsp_pkg::*;

    localparam int NB  = MAX_POINTS + MAX_DEGREE;
    localparam int BAW = $clog2(NB);
    localparam int PAW = $clog2(MAX_POINTS);
    localparam int KAW = $clog2(MAX_KNOTS);
    localparam int JW  = $clog2(NB + 1);
    localparam int IW  = JW + 1;
    localparam int LW  = $clog2(MAX_DEGREE + 1);
    localparam int AW  = 34 + PAW + 1;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_LOAD    = 12'b0000_0000_0010,
        ST_DIV1    = 12'b0000_0000_0100,
        ST_DIV2    = 12'b0000_0000_1000,
        ST_MUL1    = 12'b0000_0001_0000,
        ST_MUL2    = 12'b0000_0010_0000,
        ST_STORE   = 12'b0000_0100_0000,
        ST_ACC_RD  = 12'b0000_1000_0000,
        ST_ACC_MX  = 12'b0001_0000_0000,
        ST_ACC_MY  = 12'b0010_0000_0000,
        ST_ACC_ADD = 12'b0100_0000_0000,
        ST_FIN     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;

    logic [1:0]  degree_reg;
    logic [4:0]  num_points_reg;
    logic [15:0] val_reg;
    logic [JW-1:0] count_reg, np_reg, j_reg;
    logic [LW-1:0] dg_reg, lvl_reg;
    logic [2:0]  ph_reg;
    logic        koor_reg;
    logic [15:0] k0_reg, k1_reg, kd_reg, kd1_reg;
    basis_t      b0_reg, b1_reg, r1_reg, r2_reg;
    logic signed [35:0] p_reg;
    logic signed [20:0] s1_reg;
    logic signed [15:0] py_reg;
    logic signed [33:0] pa_reg;
    logic signed [AW-1:0] accx_reg, accy_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    logic        s_fire;
    logic [1:0]  in_func;
    logic [4:0]  in_index;
    logic [JW-1:0] np_calc;
    logic [LW-1:0] dg_calc;

    assign s_fire   = s_tvalid && s_tready;
    assign in_func  = s_tuser;
    assign in_index = s_tdata[4:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb begin
        if (num_points_reg == 5'd0) begin
            np_calc = JW'(1);
        end else if (32'(num_points_reg) > MAX_POINTS) begin
            np_calc = JW'(MAX_POINTS);
        end else begin
            np_calc = JW'(num_points_reg);
        end
        dg_calc = (32'(degree_reg) > MAX_DEGREE) ? LW'(MAX_DEGREE) : LW'(degree_reg);
    end

    // memories
    logic          pt_we, kn_we, bs_we;
    logic [31:0]   pt_rdata;
    logic [15:0]   kn_rdata;
    logic [17:0]   bs_rdata, bs_wdata;
    logic [IW-1:0] kaddr;
    logic [JW-1:0] baddr;

    assign pt_we = s_fire && (in_func == FUNC_POINT) && (32'(in_index) < MAX_POINTS);
    assign kn_we = s_fire && (in_func == FUNC_KNOT) && (32'(in_index) < MAX_KNOTS);

    bsp_ram #(.W(32), .DEPTH(MAX_POINTS)) u_pt_ram (
        .aclk(aclk), .we(pt_we), .waddr(PAW'(in_index)), .wdata(s_tdata[36:5]),
        .raddr(PAW'(j_reg)), .rdata(pt_rdata)
    );

    bsp_ram #(.W(16), .DEPTH(MAX_KNOTS)) u_kn_ram (
        .aclk(aclk), .we(kn_we), .waddr(KAW'(in_index)), .wdata(s_tdata[52:37]),
        .raddr(KAW'(kaddr)), .rdata(kn_rdata)
    );

    bsp_ram #(.W(18), .DEPTH(NB)) u_bs_ram (
        .aclk(aclk), .we(bs_we), .waddr(BAW'(j_reg)), .wdata(bs_wdata),
        .raddr(BAW'(baddr)), .rdata(bs_rdata)
    );

    always_comb begin
        case (ph_reg)
            3'd0:    kaddr = IW'(j_reg);
            3'd1:    kaddr = IW'(j_reg) + IW'(1);
            3'd2:    kaddr = IW'(j_reg) + IW'(lvl_reg);
            default: kaddr = IW'(j_reg) + IW'(lvl_reg) + IW'(1);
        endcase
        if (state_reg == ST_LOAD && ph_reg == 3'd1) begin
            baddr = j_reg + JW'(1);
        end else begin
            baddr = j_reg;
        end
    end

    // divider
    logic              div_start, div_done;
    basis_t            div_quo;
    logic signed [16:0] div_num, div_span;

    assign div_start = (state_reg == ST_LOAD && ph_reg == 3'd4 && lvl_reg != '0) ||
                       (state_reg == ST_DIV1 && div_done);
    always_comb begin
        if (state_reg == ST_LOAD) begin
            div_num  = $signed({1'b0, val_reg}) - $signed({1'b0, k0_reg});
            div_span = $signed({1'b0, kd_reg}) - $signed({1'b0, k0_reg});
        end else begin
            div_num  = $signed({1'b0, kd1_reg}) - $signed({1'b0, val_reg});
            div_span = $signed({1'b0, kd1_reg}) - $signed({1'b0, k1_reg});
        end
    end

    bsp_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .num(div_num),
        .span(div_span), .done(div_done), .quo(div_quo)
    );

    // basis arithmetic
    logic signed [35:0] p_round;
    logic signed [20:0] s2;
    logic signed [21:0] bsum;
    basis_t             bnew, binit;
    logic               last_j, last_lvl;

    assign p_round = p_reg + (p_reg[35] ? 36'sd32767 : 36'sd0);
    assign s2      = p_round[35:15];
    assign bsum    = 22'(s1_reg) + 22'(s2);
    assign bnew    = (bsum > 22'(B_MAX)) ? B_MAX :
                     (bsum < 22'(B_MIN)) ? B_MIN : 18'(bsum);
    assign binit   = (val_reg >= k0_reg && val_reg < k1_reg) ? ONE_Q15 : '0;
    assign bs_we   = (state_reg == ST_STORE) ||
                     (state_reg == ST_LOAD && ph_reg == 3'd4 && lvl_reg == '0);
    assign bs_wdata = (state_reg == ST_STORE) ? bnew : binit;
    assign last_j   = (j_reg + JW'(1)) == (count_reg - JW'(lvl_reg));
    assign last_lvl = (lvl_reg == dg_reg);

    // final scaling
    logic signed [AW-1:0] ax_round, ay_round;
    logic signed [AW-16:0] sx, sy;
    logic                  satx, saty;
    logic signed [15:0]    cx, cy;

    assign ax_round = accx_reg + (accx_reg[AW-1] ? AW'(32767) : AW'(0));
    assign ay_round = accy_reg + (accy_reg[AW-1] ? AW'(32767) : AW'(0));
    assign sx = ax_round[AW-1:15];
    assign sy = ay_round[AW-1:15];
    always_comb begin
        satx = 1'b1;
        saty = 1'b1;
        if (sx > (AW-15)'(32767)) begin
            cx = 16'sh7fff;
        end else if (sx < -(AW-15)'(32768)) begin
            cx = -16'sh8000;
        end else begin
            cx = 16'(sx);
            satx = 1'b0;
        end
        if (sy > (AW-15)'(32767)) begin
            cy = 16'sh7fff;
        end else if (sy < -(AW-15)'(32768)) begin
            cy = -16'sh8000;
        end else begin
            cy = 16'(sy);
            saty = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg     <= 2'd3;
            num_points_reg <= 5'd4;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                REG_DEGREE:     degree_reg     <= cfg_data[1:0];
                REG_NUM_POINTS: num_points_reg <= cfg_data;
                default:        degree_reg     <= degree_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            ph_reg       <= '0;
            j_reg        <= '0;
            lvl_reg      <= '0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && in_func == FUNC_EVAL) begin
                        state_reg <= ST_LOAD;
                        ph_reg    <= '0;
                        j_reg     <= '0;
                        lvl_reg   <= '0;
                    end
                end
                ST_LOAD: begin
                    ph_reg <= ph_reg + 3'd1;
                    if (ph_reg == 3'd4) begin
                        ph_reg <= '0;
                        if (lvl_reg != '0) begin
                            state_reg <= ST_DIV1;
                        end else if (last_j) begin
                            j_reg <= '0;
                            if (last_lvl) begin
                                state_reg <= ST_ACC_RD;
                            end else begin
                                lvl_reg <= lvl_reg + LW'(1);
                            end
                        end else begin
                            j_reg <= j_reg + JW'(1);
                        end
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        state_reg <= ST_DIV2;
                    end
                end
                ST_DIV2: begin
                    if (div_done) begin
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1: state_reg <= ST_MUL2;
                ST_MUL2: state_reg <= ST_STORE;
                ST_STORE: begin
                    state_reg <= ST_LOAD;
                    if (last_j) begin
                        j_reg <= '0;
                        if (last_lvl) begin
                            state_reg <= ST_ACC_RD;
                        end else begin
                            lvl_reg <= lvl_reg + LW'(1);
                        end
                    end else begin
                        j_reg <= j_reg + JW'(1);
                    end
                end
                ST_ACC_RD:  state_reg <= ST_ACC_MX;
                ST_ACC_MX:  state_reg <= ST_ACC_MY;
                ST_ACC_MY:  state_reg <= ST_ACC_ADD;
                ST_ACC_ADD: begin
                    if ((j_reg + JW'(1)) == np_reg) begin
                        state_reg <= ST_FIN;
                    end else begin
                        j_reg     <= j_reg + JW'(1);
                        state_reg <= ST_ACC_RD;
                    end
                end
                ST_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && in_func == FUNC_EVAL) begin
            val_reg   <= s_tdata[52:37];
            np_reg    <= np_calc;
            dg_reg    <= dg_calc;
            count_reg <= np_calc + JW'(dg_calc);
        end
        koor_reg <= (32'(kaddr) >= MAX_KNOTS);
        if (state_reg == ST_LOAD) begin
            case (ph_reg)
                3'd1:    k0_reg  <= koor_reg ? 16'd0 : kn_rdata;
                3'd2:    k1_reg  <= koor_reg ? 16'd0 : kn_rdata;
                3'd3:    kd_reg  <= koor_reg ? 16'd0 : kn_rdata;
                3'd4:    kd1_reg <= koor_reg ? 16'd0 : kn_rdata;
                default: kd1_reg <= kd1_reg;
            endcase
            if (ph_reg == 3'd1) begin
                b0_reg <= bs_rdata;
            end
            if (ph_reg == 3'd2) begin
                b1_reg <= bs_rdata;
            end
        end
        if (state_reg == ST_DIV1 && div_done) begin
            r1_reg <= div_quo;
        end
        if (state_reg == ST_DIV2 && div_done) begin
            r2_reg <= div_quo;
        end
        if (state_reg == ST_MUL1) begin
            p_reg <= r1_reg * b0_reg;
        end
        if (state_reg == ST_MUL2) begin
            s1_reg <= s2;
            p_reg  <= r2_reg * b1_reg;
        end
        if (state_reg == ST_LOAD && ph_reg == 3'd4 && lvl_reg == dg_reg && last_j) begin
            accx_reg <= '0;
            accy_reg <= '0;
        end
        if (state_reg == ST_STORE && last_j && last_lvl) begin
            accx_reg <= '0;
            accy_reg <= '0;
        end
        if (state_reg == ST_ACC_MX) begin
            py_reg <= $signed(pt_rdata[31:16]);
            b0_reg <= bs_rdata;
            pa_reg <= $signed(pt_rdata[15:0]) * $signed(bs_rdata);
        end
        if (state_reg == ST_ACC_MY) begin
            accx_reg <= accx_reg + AW'(pa_reg);
            pa_reg   <= py_reg * b0_reg;
        end
        if (state_reg == ST_ACC_ADD) begin
            accy_reg <= accy_reg + AW'(pa_reg);
        end
        if (state_reg == ST_FIN && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {cy, cx};
            m_tuser_reg <= satx || saty;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_bs_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bs_we |-> (j_reg < count_reg)) else $error("basis write past count");
    a_eval_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_func == FUNC_EVAL) |=> (state_reg == ST_LOAD))
        else $error("evaluate beat did not start walk");
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result without finish");
    a_lvl_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (lvl_reg <= dg_reg)) else $error("level beyond degree");

endmodule
`default_nettype wire

FILE: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bsp_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int N_PTS = MAX_POINTS_DEF;
    localparam int N_KNOTS = MAX_KNOTS_DEF;
    localparam int N_DEG = MAX_DEGREE_DEF;
    localparam longint Q_ONE = 32768;
    localparam longint BAS_HI = 131071;
    localparam longint BAS_LO = -131072;

    typedef struct {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic               sat;
    } curve_pt_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_addr = 1'b0;
    logic [4:0]  cfg_data = '0;

    bspline_curve_point_eval_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the block state
    logic [1:0]         sh_degree;
    logic [4:0]         sh_npts;
    logic signed [15:0] sh_px [N_PTS];
    logic signed [15:0] sh_py [N_PTS];
    logic [15:0]        sh_knot [N_KNOTS];

    curve_pt_t curve_q[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic longint knot_val(int i);
        if (i < 0 || i >= N_KNOTS) return 0;
        return longint'(sh_knot[i]);
    endfunction

    function automatic longint sat_range(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint span_ratio(longint num, longint span);
        if (span == 0) span = Q_ONE;
        return sat_range((num * Q_ONE) / span, BAS_LO, BAS_HI);
    endfunction

    function automatic curve_pt_t eval_curve(logic [15:0] t_in);
        curve_pt_t r;
        longint basis [N_PTS + N_DEG];
        longint t, sx, sy, r1, r2, cx, cy;
        int np, dg, cnt;
        t = longint'(t_in);
        np = int'(sh_npts);
        dg = int'(sh_degree);
        if (np < 1) np = 1;
        if (np > N_PTS) np = N_PTS;
        if (dg > N_DEG) dg = N_DEG;
        cnt = np + dg;
        for (int j = 0; j < cnt; j++)
            basis[j] = (t >= knot_val(j) && t < knot_val(j + 1)) ? Q_ONE : 0;
        for (int d = 1; d <= dg; d++)
            for (int j = 0; j < cnt - d; j++) begin
                r1 = span_ratio(t - knot_val(j), knot_val(j + d) - knot_val(j));
                r2 = span_ratio(knot_val(j + d + 1) - t,
                                knot_val(j + d + 1) - knot_val(j + 1));
                basis[j] = sat_range((r1 * basis[j]) / Q_ONE + (r2 * basis[j + 1]) / Q_ONE,
                                     BAS_LO, BAS_HI);
            end
        sx = 0;
        sy = 0;
        for (int j = 0; j < np; j++) begin
            sx += longint'(sh_px[j]) * basis[j];
            sy += longint'(sh_py[j]) * basis[j];
        end
        sx = sx / Q_ONE;
        sy = sy / Q_ONE;
        cx = sat_range(sx, -32768, 32767);
        cy = sat_range(sy, -32768, 32767);
        r.cx = cx[15:0];
        r.cy = cy[15:0];
        r.sat = (cx != sx) || (cy != sy);
        return r;
    endfunction

    task automatic send_item(logic [1:0] f, logic [4:0] idx, logic [15:0] px,
                             logic [15:0] py, logic [15:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, v, py, px, idx};
        s_tuser <= f;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (f)
            FUNC_POINT: if (idx < N_PTS) begin
                sh_px[idx] = px;
                sh_py[idx] = py;
            end
            FUNC_KNOT: if (idx < N_KNOTS) sh_knot[idx] = v;
            FUNC_EVAL: curve_q.push_back(eval_curve(v));
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (curve_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic a, logic [4:0] d);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_addr <= a;
        cfg_data <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (a == REG_DEGREE) sh_degree = d[1:0];
        else sh_npts = d;
    endtask

    task automatic set_shape(logic [4:0] dg, logic [4:0] np);
        write_reg(REG_DEGREE, dg);
        write_reg(REG_NUM_POINTS, np);
    endtask

    task automatic load_clamped_knots();
        for (int k = 0; k < N_KNOTS; k++)
            send_item(FUNC_KNOT, k[4:0], '0, '0,
                      k < 4 ? 16'd0 : (k > 15 ? 16'd32768 : 16'((k - 3) * 32768 / 13)));
    endtask

    task automatic load_sorted_random_knots();
        int kv [N_KNOTS];
        foreach (kv[k]) kv[k] = $urandom_range(32768);
        kv.sort();
        for (int k = 0; k < N_KNOTS; k++)
            send_item(FUNC_KNOT, k[4:0], '0, '0, 16'(kv[k]));
    endtask

    // receiver: check each result beat against the oldest expected point
    always @(posedge aclk) begin
        curve_pt_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (curve_q.size() == 0) begin
                $display("%0t unexpected result x=%0d y=%0d sat=%0d", $time,
                         $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser[0]);
                errors++;
            end else begin
                want = curve_q.pop_front();
                if (m_tdata[15:0] !== want.cx) begin
                    $display("%0t curve_x expected %0d actual %0d", $time, want.cx,
                             $signed(m_tdata[15:0]));
                    errors++;
                end
                if (m_tdata[31:16] !== want.cy) begin
                    $display("%0t curve_y expected %0d actual %0d", $time, want.cy,
                             $signed(m_tdata[31:16]));
                    errors++;
                end
                if (m_tuser[0] !== want.sat) begin
                    $display("%0t saturated expected %0d actual %0d", $time, want.sat,
                             m_tuser[0]);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_load_tables();
        for (int i = 0; i < N_PTS; i++)
            send_item(FUNC_POINT, i[4:0], 16'($urandom), 16'($urandom), '0);
        load_clamped_knots();
    endtask

    task automatic test_directed();
        send_item(FUNC_EVAL, '0, '0, '0, 16'd0);
        send_item(FUNC_EVAL, '0, '0, '0, 16'd32768);
        send_item(FUNC_EVAL, '0, '0, '0, 16'd12345);
        // out of range writes and the unused code are dropped
        send_item(FUNC_POINT, 5'd16, 16'h7fff, 16'h8000, '0);
        send_item(FUNC_POINT, 5'd31, 16'h8000, 16'h7fff, '0);
        send_item(FUNC_KNOT, 5'd20, '0, '0, 16'd1);
        send_item(FUNC_KNOT, 5'd31, '0, '0, 16'd32768);
        send_item(FUNC_UNUSED, 5'd3, 16'hffff, 16'hffff, 16'hffff);
        send_item(FUNC_EVAL, '0, '0, '0, 16'd20000);
        // extreme points, unsorted knots to push basis past one
        for (int i = 0; i < 4; i++)
            send_item(FUNC_POINT, i[4:0], i[0] ? 16'h8000 : 16'h7fff,
                      i[0] ? 16'h7fff : 16'h8000, '0);
        send_item(FUNC_KNOT, 5'd4, '0, '0, 16'd30000);
        send_item(FUNC_KNOT, 5'd5, '0, '0, 16'd100);
        send_item(FUNC_EVAL, '0, '0, '0, 16'd200);
        send_item(FUNC_EVAL, '0, '0, '0, 16'd30000);
        for (int dg = 0; dg <= 3; dg++) begin
            set_shape(dg[4:0], dg[0] ? 5'd16 : 5'd1);
            send_item(FUNC_EVAL, '0, '0, '0, 16'd0);
            send_item(FUNC_EVAL, '0, '0, '0, 16'd16384);
        end
        // point counts outside the legal range are clamped
        set_shape(5'd2, 5'd0);
        send_item(FUNC_EVAL, '0, '0, '0, 16'd5000);
        set_shape(5'd3, 5'd31);
        send_item(FUNC_EVAL, '0, '0, '0, 16'd32767);
        load_clamped_knots();
    endtask

    task automatic random_items(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 2) load_sorted_random_knots();
            if (pick < 35)
                send_item(FUNC_EVAL, 5'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom_range(32768)));
            else if (pick < 62)
                send_item(FUNC_POINT, 5'($urandom_range(15)), 16'($urandom), 16'($urandom),
                          16'($urandom));
            else if (pick < 92)
                send_item(FUNC_KNOT, 5'($urandom_range(19)), 16'($urandom), 16'($urandom),
                          16'($urandom_range(32768)));
            else
                send_item($urandom_range(1) ? FUNC_UNUSED : 2'($urandom_range(1)),
                          5'($urandom_range(31, 16)), 16'($urandom), 16'($urandom),
                          16'($urandom_range(32768)));
        end
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct);
        wait_idle();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int b = 0; b < 4; b++) begin
            set_shape(5'($urandom_range(3)),
                      $urandom_range(9) == 0 ? 5'd16 : 5'($urandom_range(6, 1)));
            random_items(70);
        end
    endtask

    initial begin
        sh_degree = 2'd3;
        sh_npts = 5'd4;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_load_tables();
        test_directed();
        test_random_phase(0, 0);
        test_random_phase(54, 0);
        test_random_phase(0, 54);
        test_random_phase(10, 10);
        wait_idle();
        repeat (100) @(posedge aclk);
        if (errors == 0 && curve_q.size() == 0) begin
            $display("bspline_curve_point_eval_unit verification clean");
        end else begin
            $display("bspline_curve_point_eval_unit verification failed");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("bspline_curve_point_eval_unit verification failed");
        $finish;
    end
endmodule
